[hdl/assert_macros.svh]
// Assertion macros shared by the RTL of the stick conditioner.
// Needs clk and arst_n in the scope of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property checked at every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`endif

[hdl/rcs_pkg.sv]
// Types and constants of the stick conditioner.
// No dependencies; used by every module of the block.
package rcs_pkg;
	localparam int unsigned NUM_CH = 4;
	localparam logic [10:0] STICK_CENTER = 11'd1024;
	localparam logic [15:0] NORM_ONE = 16'd16384;

	typedef enum logic [2:0] {
		REG_DEADBAND  = 3'd0,
		REG_SPAN_INV  = 3'd1,
		REG_THRESHOLD = 3'd2,
		REG_HOLD      = 3'd3,
		REG_TIMEOUT   = 3'd4,
		REG_GAIN_FWD  = 3'd5,
		REG_GAIN_SIDE = 3'd6,
		REG_GAIN_TURN = 3'd7
	} reg_idx_t;

	localparam logic OP_FRAME = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	localparam logic [1:0] POS_UP      = 2'd0;
	localparam logic [1:0] POS_MID     = 2'd1;
	localparam logic [1:0] POS_DOWN    = 2'd2;
	localparam logic [1:0] POS_UNKNOWN = 2'd3;

	typedef struct packed {
		logic [9:0]         deadband;
		logic [23:0]        span_inv;
		logic [15:0]        threshold;
		logic [31:0]        hold;
		logic [31:0]        timeout;
		logic signed [15:0] gain_fwd;
		logic signed [15:0] gain_side;
		logic signed [15:0] gain_turn;
	} cfg_t;

	// one centred channel: sign and magnitude
	typedef struct packed {
		logic        neg;
		logic [10:0] mag;
	} chan_t;

	typedef struct packed {
		logic        op;
		logic [31:0] now_ms;
		chan_t [NUM_CH-1:0] ch;
		logic [1:0]  s1_pos;
		logic [1:0]  s2_pos;
	} item_t;

	typedef struct packed {
		logic signed [NUM_CH-1:0][15:0] norm;
		logic [1:0]  s1_pos;
		logic [1:0]  s2_pos;
		logic        link_online;
		logic        takeover;
		logic        mode_request;
		logic signed [15:0] vx_cmd;
		logic signed [15:0] vy_cmd;
		logic signed [15:0] wz_cmd;
	} result_t;
endpackage

[hdl/rcs_front.sv]
// Front end: centres the raw channels and decodes the switch codes.
// Depends on rcs_pkg.
module rcs_front import rcs_pkg::*; (
	input  logic        op,
	input  logic [31:0] now_ms,
	input  logic [10:0] ch0,
	input  logic [10:0] ch1,
	input  logic [10:0] ch2,
	input  logic [10:0] ch3,
	input  logic [1:0]  s1_code,
	input  logic [1:0]  s2_code,
	output item_t       item
);
	function automatic logic [1:0] dec_sw(input logic [1:0] code);
		logic [1:0] p;
		case (code)
			2'd1: p = POS_UP;
			2'd3: p = POS_MID;
			2'd2: p = POS_DOWN;
			default: p = POS_UNKNOWN;
		endcase
		return p;
	endfunction

	function automatic chan_t centre(input logic [10:0] raw);
		chan_t c;
		c.neg = raw < STICK_CENTER;
		c.mag = c.neg ? (STICK_CENTER - raw) : (raw - STICK_CENTER);
		return c;
	endfunction

	always_comb begin
		item.op     = op;
		item.now_ms = now_ms;
		item.ch[0]  = centre(ch0);
		item.ch[1]  = centre(ch1);
		item.ch[2]  = centre(ch2);
		item.ch[3]  = centre(ch3);
		item.s1_pos = dec_sw(s1_code);
		item.s2_pos = dec_sw(s2_code);
	end
endmodule

[hdl/rcs_queue.sv]
// Small FIFO between front and back end.
// Depends on rcs_pkg for the item type.
module rcs_queue import rcs_pkg::*; #(
	parameter int unsigned DEPTH = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t wr_item,
	output logic  full,
	input  logic  pop,
	output item_t rd_item,
	output logic  empty
);
	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	item_t         mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full    = count_q == CW'(DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

[hdl/rcs_back.sv]
// Back end: sequencer with one multiplier for normalisation and one for velocity
// scaling, holds the conditioner state and the result register. Uses rcs_pkg.
module rcs_back import rcs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  item_t   q_item,
	input  logic    q_empty,
	output logic    q_pop,
	output result_t res,
	output logic    res_valid,
	input  logic    res_pop
);
	`include "assert_macros.svh"

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_NORM = 4'b0010,
		ST_CMD  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t   state_q;
	logic [1:0] cnt_q;
	item_t    cur_q;
	logic signed [15:0] norm_q [NUM_CH];
	logic signed [15:0] cmd_q [3];
	logic [1:0]  s1_q, s2_q;
	logic        online_q, take_q;
	logic [31:0] start_q, last_q;
	result_t     res_q;
	logic        res_valid_q;
	logic        res_hold;

	// normalisation of the selected channel
	chan_t       nch;
	logic [34:0] nprod;
	logic [25:0] nround;
	logic [15:0] nmag;
	logic signed [15:0] nval;

	always_comb begin
		nch    = cur_q.ch[cnt_q];
		nprod  = 35'(nch.mag) * 35'(cfg.span_inv);
		nround = 26'((nprod + 35'd512) >> 10);
		nmag   = (nround > 26'(NORM_ONE)) ? NORM_ONE : nround[15:0];
		if ({1'b0, nch.mag} <= {2'b00, cfg.deadband}) begin
			nval = '0;
		end else begin
			nval = nch.neg ? -$signed(nmag) : $signed(nmag);
		end
	end

	// velocity scaling: vx from norm3, vy from norm2, wz from norm0
	logic signed [15:0] snorm, sgain;
	logic signed [31:0] sprod;
	logic signed [17:0] sq;
	logic signed [15:0] sval;

	always_comb begin
		case (cnt_q)
			2'd0:    begin snorm = norm_q[3]; sgain = cfg.gain_fwd;  end
			2'd1:    begin snorm = norm_q[2]; sgain = cfg.gain_side; end
			default: begin snorm = norm_q[0]; sgain = cfg.gain_turn; end
		endcase
		sprod = snorm * sgain;
		sq    = sprod[31:14];
		if (sq > 18'sd32767) begin
			sval = 16'sh7fff;
		end else if (sq < -18'sd32768) begin
			sval = 16'sh8000;
		end else begin
			sval = sq[15:0];
		end
	end

	// final state update
	logic [14:0] a0, a2, a3;
	logic [16:0] act;
	logic [31:0] start_eff;
	logic        n_online, n_take;
	logic [31:0] n_start;
	logic [1:0]  n_s1, n_s2;
	logic        fin_go;

	function automatic logic [14:0] absn(input logic signed [15:0] v);
		logic signed [15:0] t;
		t = v[15] ? -v : v;
		return t[14:0];
	endfunction

	always_comb begin
		a0        = absn(norm_q[0]);
		a2        = absn(norm_q[2]);
		a3        = absn(norm_q[3]);
		act       = 17'(a0) + 17'(a2) + 17'(a3);
		start_eff = (start_q == '0) ? cur_q.now_ms : start_q;
		n_online  = online_q;
		n_take    = take_q;
		n_start   = start_q;
		n_s1      = s1_q;
		n_s2      = s2_q;
		if (cur_q.op == OP_FRAME) begin
			n_online = 1'b1;
			n_s1     = cur_q.s1_pos;
			n_s2     = cur_q.s2_pos;
			if (act >= 17'(cfg.threshold)) begin
				n_start = start_eff;
				n_take  = (cur_q.now_ms - start_eff) >= cfg.hold;
			end else begin
				n_start = '0;
				n_take  = 1'b0;
			end
		end else if ((cur_q.now_ms - last_q) >= cfg.timeout) begin
			n_online = 1'b0;
			n_take   = 1'b0;
			n_start  = '0;
		end
		fin_go = (state_q == ST_FIN) && (!res_valid_q || res_pop);
	end

	assign q_pop     = (state_q == ST_IDLE) && !q_empty;
	assign res       = res_q;
	assign res_valid = res_valid_q;
	assign res_hold  = res_valid_q && !res_pop && state_q == ST_FIN;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_item;
		end
		if (state_q == ST_CMD) begin
			cmd_q[cnt_q] <= sval;
		end
		if (fin_go) begin
			res_q.norm[0]      <= norm_q[0];
			res_q.norm[1]      <= norm_q[1];
			res_q.norm[2]      <= norm_q[2];
			res_q.norm[3]      <= norm_q[3];
			res_q.s1_pos       <= n_s1;
			res_q.s2_pos       <= n_s2;
			res_q.link_online  <= n_online;
			res_q.takeover     <= n_take;
			res_q.mode_request <= n_online && (n_s1 == POS_MID || n_s1 == POS_DOWN);
			res_q.vx_cmd       <= cmd_q[0];
			res_q.vy_cmd       <= cmd_q[1];
			res_q.wz_cmd       <= cmd_q[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			for (int i = 0; i < NUM_CH; i++) norm_q[i] <= '0;
			s1_q        <= POS_UNKNOWN;
			s2_q        <= POS_UNKNOWN;
			online_q    <= 1'b0;
			take_q      <= 1'b0;
			start_q     <= '0;
			last_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_pop && res_valid_q && !fin_go) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (!q_empty) begin
						state_q <= (q_item.op == OP_FRAME) ? ST_NORM : ST_CMD;
					end
				end
				ST_NORM: begin
					norm_q[cnt_q] <= nval;
					cnt_q         <= cnt_q + 1'b1;
					if (cnt_q == 2'(NUM_CH - 1)) begin
						state_q <= ST_CMD;
					end
				end
				ST_CMD: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 2'd2) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						s1_q        <= n_s1;
						s2_q        <= n_s2;
						online_q    <= n_online;
						take_q      <= n_take;
						start_q     <= n_start;
						if (cur_q.op == OP_FRAME) begin
							last_q <= cur_q.now_ms;
						end
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_CLK(a_take_needs_link, take_q |-> online_q, "takeover set while link offline")
	`ASSERT_CLK(a_no_overwrite, res_hold |=> res_valid_q && $stable(res_q), "result overwritten")
	`ASSERT_NEVER(a_pop_busy, q_pop && state_q != ST_IDLE, "queue popped while busy")
endmodule

[hdl/rc_stick_conditioner.sv]
// Remote-control stick conditioner. Each transaction is a frame or a time tick;
// each gives exactly one result. In the back end a frame takes a load step, 4
// normalisation steps on one multiplier, 3 velocity steps on a second and an
// update, a tick the same without the normalisation steps; the front end and a
// QUEUE_DEPTH-entry queue accept new transactions meanwhile, and one result register
// holds the finished result until popped. Configuration is written through
// cfg_valid/cfg_ready (always ready) and must only happen while the block is idle.
// Depends on rcs_pkg, rcs_front, rcs_queue, rcs_back.
module rc_stick_conditioner import rcs_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	// input transactions
	input  logic        push,
	output logic        full,
	input  logic        op,
	input  logic [31:0] now_ms,
	input  logic [10:0] ch0,
	input  logic [10:0] ch1,
	input  logic [10:0] ch2,
	input  logic [10:0] ch3,
	input  logic [1:0]  s1_code,
	input  logic [1:0]  s2_code,
	// results
	output logic        empty,
	input  logic        pop,
	output logic signed [15:0] norm0,
	output logic signed [15:0] norm1,
	output logic signed [15:0] norm2,
	output logic signed [15:0] norm3,
	output logic [1:0]  s1_pos,
	output logic [1:0]  s2_pos,
	output logic        link_online,
	output logic        takeover,
	output logic        mode_request,
	output logic signed [15:0] vx_cmd,
	output logic signed [15:0] vy_cmd,
	output logic signed [15:0] wz_cmd,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	cfg_t    cfg_q;
	item_t   f_item, q_item;
	logic    q_empty, q_pop;
	result_t res;
	logic    res_valid;

	assign cfg_ready = 1'b1;

	// register file, reset to the documented defaults
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.deadband  <= 10'd10;
			cfg_q.span_inv  <= 24'd25420;
			cfg_q.threshold <= 16'd4915;
			cfg_q.hold      <= 32'd200;
			cfg_q.timeout   <= 32'd100;
			cfg_q.gain_fwd  <= 16'sd2000;
			cfg_q.gain_side <= 16'sd2000;
			cfg_q.gain_turn <= 16'sd3000;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_DEADBAND:  cfg_q.deadband  <= cfg_data[9:0];
				REG_SPAN_INV:  cfg_q.span_inv  <= cfg_data[23:0];
				REG_THRESHOLD: cfg_q.threshold <= cfg_data[15:0];
				REG_HOLD:      cfg_q.hold      <= cfg_data;
				REG_TIMEOUT:   cfg_q.timeout   <= cfg_data;
				REG_GAIN_FWD:  cfg_q.gain_fwd  <= cfg_data[15:0];
				REG_GAIN_SIDE: cfg_q.gain_side <= cfg_data[15:0];
				REG_GAIN_TURN: cfg_q.gain_turn <= cfg_data[15:0];
				default:       cfg_q <= cfg_q;
			endcase
		end
	end

	rcs_front u_front (
		.op(op), .now_ms(now_ms), .ch0(ch0), .ch1(ch1), .ch2(ch2), .ch3(ch3),
		.s1_code(s1_code), .s2_code(s2_code), .item(f_item)
	);

	rcs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wr_item(f_item), .full(full),
		.pop(q_pop), .rd_item(q_item), .empty(q_empty)
	);

	rcs_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .q_item(q_item), .q_empty(q_empty),
		.q_pop(q_pop), .res(res), .res_valid(res_valid), .res_pop(pop)
	);

	assign empty        = !res_valid;
	assign norm0        = res.norm[0];
	assign norm1        = res.norm[1];
	assign norm2        = res.norm[2];
	assign norm3        = res.norm[3];
	assign s1_pos       = res.s1_pos;
	assign s2_pos       = res.s2_pos;
	assign link_online  = res.link_online;
	assign takeover     = res.takeover;
	assign mode_request = res.mode_request;
	assign vx_cmd       = res.vx_cmd;
	assign vy_cmd       = res.vy_cmd;
	assign wz_cmd       = res.wz_cmd;
endmodule
